// ===== src/pbs_pkg.sv =====
// Package for the polyBLEP sawtooth shaper: widths, Q30 spline constants,
// stage counts, the side-band struct and the rounded Q30 multiply.
// No dependencies.
package pbs_pkg;

  // Phase width default and fixed datapath widths
  localparam int PHASE_BITS_DEF     = 24;
  localparam int RATIO_BITS         = 31;   // Q1.30 ratio, below 2
  localparam int DIV_BITS_PER_STAGE = 4;
  localparam int DIV_STAGES         = (RATIO_BITS + DIV_BITS_PER_STAGE - 1) / DIV_BITS_PER_STAGE;
  localparam int HORNER_STEPS       = 4;
  localparam int T_W                = 34;   // signed Q30 spline terms
  localparam int PROD_W             = T_W + RATIO_BITS;
  localparam int Q30_SHIFT          = 30;
  localparam int ACC_W              = 38;   // signed Q32 sum
  localparam int NAIVE_W            = 33;   // signed Q32 naive ramp
  localparam int DROP_BITS          = 10;   // Q32 -> Q22
  localparam int ROUND_HALF         = 1 << (DROP_BITS - 1);
  localparam int SAMPLE_W           = 24;
  localparam int SAT_MAX            = (1 << (SAMPLE_W - 1)) - 1;
  localparam int SAT_MIN            = -(1 << (SAMPLE_W - 1));

  // Configuration port
  localparam int   CFG_ADDR_W    = 3;
  localparam int   CFG_DATA_W    = 32;
  localparam int   CFG_IDX_BIT   = 2;
  localparam logic REG_ANTIALIAS = 1'b0;

  typedef logic signed [T_W-1:0] coef_t;

  // Spline constants, Q30 rounded to nearest
  localparam coef_t Q_ONE          = 34'sd1073741824;
  localparam coef_t Q_QUARTER      = 34'sd268435456;
  localparam coef_t Q_TWO_THIRDS   = 34'sd715827883;
  localparam coef_t Q_FOUR_THIRDS  = 34'sd1431655765;
  localparam coef_t Q_TWELFTH      = 34'sd89478485;
  localparam coef_t Q_EIGHT_THIRDS = 34'sd2863311531;
  localparam coef_t Q_TWO          = 34'sd2147483648;

  // Side band that rides along the pipeline
  typedef struct packed {
    logic signed [NAIVE_W-1:0] acc;      // naive ramp, Q32
    logic                      en_rest;  // add residual of (1-phase)/step
    logic                      en_ph;    // subtract residual of phase/step
    logic                      eob;
  } side_t;

  // Q30 product of a signed term and an unsigned ratio; magnitude rounded
  // to nearest, ties away from zero
  function automatic coef_t mul_q30(input coef_t a, input logic [RATIO_BITS-1:0] x);
    logic [T_W-1:0]    mag;
    logic [PROD_W-1:0] prod;
    logic [T_W-1:0]    rnd;
    mag  = a[T_W-1] ? T_W'(-a) : T_W'(a);
    prod = PROD_W'(mag) * PROD_W'(x);
    prod = prod + (PROD_W'(1) << (Q30_SHIFT - 1));
    rnd  = prod[T_W+Q30_SHIFT-1:Q30_SHIFT];
    return a[T_W-1] ? -$signed(rnd) : $signed(rnd);
  endfunction

  // Leading Horner coefficient; the upper segment uses -1/12
  function automatic coef_t first_coef(input logic hi);
    return hi ? -Q_TWELFTH : Q_QUARTER;
  endfunction

  // Constant added after each Horner multiply
  function automatic coef_t horner_offset(input logic [1:0] step, input logic hi);
    coef_t off;
    case (step)
      2'd0:    off = hi ? Q_TWO_THIRDS : -Q_TWO_THIRDS;
      2'd1:    off = hi ? -Q_TWO : coef_t'(0);
      2'd2:    off = hi ? Q_EIGHT_THIRDS : Q_FOUR_THIRDS;
      default: off = hi ? -Q_FOUR_THIRDS : -Q_ONE;
    endcase
    return off;
  endfunction

endpackage

// ===== src/polyblep_sawtooth_shaper.sv =====
// Sawtooth shaper top level: input register, pipelined restoring divider,
// four-stage Horner spline, output rounding and saturation.
// Depends on pbs_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries phase, phase step and an
//   end-of-block flag; the result channel (out_valid/out_ready) returns
//   the Q2.22 sample and the copied flag. One beat in gives one beat out,
//   in order.
//   Structure: 14 register stages (input, divider, spline, output).
//   Throughput: one beat per clock unless out_ready stalls the pipe.
//   The divider produces up to 4 quotient bits per stage over 8 stages,
//   then one Q30 multiply per lane in each spline stage.
//   Stall: each stage holds its beat while the one after it is full and
//   blocked; empty stages still fill, so in_ready stays high until the
//   whole pipe is full behind a stalled out_ready.
//   Reset (rst_n low at a clock edge) empties the pipe and clears
//   antialias_enable; no clearing pass is needed.
//   APB register 0 (byte address 0), bit 0: antialias_enable. Write it
//   only while the pipe is empty.
module polyblep_sawtooth_shaper #(
  parameter int PHASE_BITS = pbs_pkg::PHASE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [PHASE_BITS-1:0]                in_phase,
  input  logic [PHASE_BITS-1:0]                in_phase_step,
  input  logic                                 in_end_of_block,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [pbs_pkg::SAMPLE_W-1:0]  out_sample_out,
  output logic                                 out_end_of_block_out,
  // configuration port
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [pbs_pkg::CFG_ADDR_W-1:0]       cfg_paddr,
  input  logic [pbs_pkg::CFG_DATA_W-1:0]       cfg_pwdata,
  output logic [pbs_pkg::CFG_DATA_W-1:0]       cfg_prdata,
  output logic                                 cfg_pready
);
  import pbs_pkg::*;

  localparam int DS        = DIV_STAGES;
  localparam int HS0       = DS + 1;               // first spline stage
  localparam int NSTG      = DS + HORNER_STEPS + 2;
  localparam int OUT_STG   = NSTG - 1;
  localparam int ACC_SHIFT = NAIVE_W - PHASE_BITS;  // phase*2 into Q32
  localparam int Q_W       = ACC_W - DROP_BITS;

  // Configuration register
  logic aa_r;
  logic cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[CFG_IDX_BIT] == REG_ANTIALIAS) ? CFG_DATA_W'(aa_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aa_r <= 1'b0;
    end else if (cfg_wr && cfg_paddr[CFG_IDX_BIT] == REG_ANTIALIAS) begin
      aa_r <= cfg_pwdata[0];
    end
  end

  // Valid bits and per-stage advance; a stage loads when empty or draining
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] adv;

  always_comb begin
    adv[OUT_STG] = !vld_r[OUT_STG] || out_ready;
    for (int i = OUT_STG - 1; i >= 0; i--) begin
      adv[i] = !vld_r[i] || adv[i+1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld_r[OUT_STG];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (adv[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
    end
  end

  // Datapath storage
  logic [PHASE_BITS:0]     rem_r [0:DS-1][2];   // lane 0: 1-phase, lane 1: phase
  logic [RATIO_BITS-1:0]   quo_r [0:DS][2];
  logic [PHASE_BITS-1:0]   inc_r [0:DS-1];
  logic [RATIO_BITS-1:0]   x_r   [0:HORNER_STEPS-2][2];
  coef_t                   t_r   [0:HORNER_STEPS-1][2];
  side_t                   side_r [0:NSTG-2];
  logic signed [SAMPLE_W-1:0] sample_r;
  logic                    eob_r;

  // Stage 0: distance to the edge, naive ramp, edge-window flags
  logic [PHASE_BITS:0] rest_w;
  logic [PHASE_BITS:0] ph_w;
  logic [PHASE_BITS:0] inc2_w;
  logic [NAIVE_W:0]    ramp_w;
  side_t               side0_w;

  always_comb begin
    ph_w    = {1'b0, in_phase};
    rest_w  = ((PHASE_BITS+1)'(1) << PHASE_BITS) - ph_w;
    inc2_w  = {in_phase_step, 1'b0};
    ramp_w  = ((NAIVE_W+1)'(in_phase) << ACC_SHIFT) - ((NAIVE_W+1)'(1) << (NAIVE_W - 1));
    side0_w.acc     = $signed(ramp_w[NAIVE_W-1:0]);
    // zero step makes both compares false
    side0_w.en_rest = aa_r && (rest_w < inc2_w);
    side0_w.en_ph   = aa_r && (ph_w < inc2_w);
    side0_w.eob     = in_end_of_block;
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      rem_r[0][0] <= rest_w;
      rem_r[0][1] <= ph_w;
      quo_r[0][0] <= '0;
      quo_r[0][1] <= '0;
      inc_r[0]    <= in_phase_step;
      side_r[0]   <= side0_w;
    end
  end

  // Side band moves with its beat
  for (genvar i = 1; i < NSTG - 1; i++) begin : g_side
    always_ff @(posedge clk) begin
      if (adv[i]) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  // Restoring divider: (num << 30) / step, a few quotient bits per stage
  for (genvar s = 1; s <= DS; s++) begin : g_div
    logic [PHASE_BITS:0]   r_v [2];
    logic [RATIO_BITS-1:0] q_v [2];

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        r_v[l] = rem_r[s-1][l];
        q_v[l] = quo_r[s-1][l];
        for (int m = 0; m < DIV_BITS_PER_STAGE; m++) begin
          if ((s - 1) * DIV_BITS_PER_STAGE + m < RATIO_BITS) begin
            if (r_v[l] >= {1'b0, inc_r[s-1]}) begin
              r_v[l] = r_v[l] - {1'b0, inc_r[s-1]};
              q_v[l] = {q_v[l][RATIO_BITS-2:0], 1'b1};
            end else begin
              q_v[l] = {q_v[l][RATIO_BITS-2:0], 1'b0};
            end
            r_v[l] = r_v[l] << 1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv[s]) begin
        quo_r[s][0] <= q_v[0];
        quo_r[s][1] <= q_v[1];
      end
    end

    if (s < DS) begin : g_carry
      always_ff @(posedge clk) begin
        if (adv[s]) begin
          rem_r[s][0] <= r_v[0];
          rem_r[s][1] <= r_v[1];
          inc_r[s]    <= inc_r[s-1];
        end
      end
    end
  end

  // Spline residual by Horner's rule, one rounded multiply per lane in each stage
  for (genvar k = 0; k < HORNER_STEPS; k++) begin : g_res
    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [RATIO_BITS-1:0] x_in;
      coef_t                 t_in;

      if (k == 0) begin : g_first
        assign x_in = quo_r[DS][l];
        assign t_in = first_coef(x_in[RATIO_BITS-1]);
      end else begin : g_next
        assign x_in = x_r[k-1][l];
        assign t_in = t_r[k-1][l];
      end

      always_ff @(posedge clk) begin
        if (adv[HS0+k]) begin
          t_r[k][l] <= mul_q30(t_in, x_in) + horner_offset(2'(k), x_in[RATIO_BITS-1]);
        end
      end

      if (k < HORNER_STEPS - 1) begin : g_keep_x
        always_ff @(posedge clk) begin
          if (adv[HS0+k]) begin
            x_r[k][l] <= x_in;
          end
        end
      end
    end
  end

  // Output: apply corrections, round Q32 to Q22 (ties up), saturate
  logic signed [ACC_W-1:0]    add_w;
  logic signed [ACC_W-1:0]    sub_w;
  logic signed [ACC_W-1:0]    sum_w;
  logic signed [Q_W-1:0]      q_w;
  logic signed [SAMPLE_W-1:0] sample_nxt;
  side_t                      side_last;

  always_comb begin
    side_last = side_r[NSTG-2];
    add_w = side_last.en_rest ? (ACC_W'(t_r[HORNER_STEPS-1][0]) <<< 2) : ACC_W'(0);
    sub_w = side_last.en_ph   ? (ACC_W'(t_r[HORNER_STEPS-1][1]) <<< 2) : ACC_W'(0);
    sum_w = ACC_W'(side_last.acc) + add_w - sub_w + ACC_W'(ROUND_HALF);
    q_w   = $signed(sum_w[ACC_W-1:DROP_BITS]);
    if (q_w > SAT_MAX) begin
      sample_nxt = SAMPLE_W'(SAT_MAX);
    end else if (q_w < SAT_MIN) begin
      sample_nxt = SAMPLE_W'(SAT_MIN);
    end else begin
      sample_nxt = SAMPLE_W'(q_w);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[OUT_STG]) begin
      sample_r <= sample_nxt;
      eob_r    <= side_last.eob;
    end
  end

  assign out_sample_out       = sample_r;
  assign out_end_of_block_out = eob_r;

endmodule

// ===== verif/polyblep_sawtooth_shaper_check.sv =====
// Checker for the polyBLEP sawtooth shaper: mirrors the antialias register
// from the APB port, predicts every sample and compares result beats in order.
// Depends on pbs_pkg.
module polyblep_sawtooth_shaper_check (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic [pbs_pkg::PHASE_BITS_DEF-1:0]  in_phase,
  input  logic [pbs_pkg::PHASE_BITS_DEF-1:0]  in_phase_step,
  input  logic                                in_end_of_block,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic signed [pbs_pkg::SAMPLE_W-1:0] out_sample_out,
  input  logic                                out_end_of_block_out,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [pbs_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [pbs_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  input  logic [pbs_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  input  logic                                cfg_pready,
  output int                                  mismatches,
  output int                                  pending
);

  localparam int PB = pbs_pkg::PHASE_BITS_DEF;

  // Spline coefficients in Q30
  localparam longint K_ONE     = 64'sd1073741824;
  localparam longint K_QUARTER = 64'sd268435456;
  localparam longint K_2_3     = 64'sd715827883;
  localparam longint K_4_3     = 64'sd1431655765;
  localparam longint K_1_12    = 64'sd89478485;
  localparam longint K_8_3     = 64'sd2863311531;
  localparam longint K_TWO     = 64'sd2147483648;
  localparam longint unsigned RATIO_CEIL = 64'd2147483647;  // 2 - 2^-30 in Q1.30
  localparam longint SAMPLE_HI = 64'sd8388607;
  localparam longint SAMPLE_LO = -64'sd8388608;

  typedef struct packed {
    logic signed [pbs_pkg::SAMPLE_W-1:0] sample;
    logic                                eob;
  } sample_beat_t;

  sample_beat_t expected_samples[$];
  logic         antialias_on;
  int           errs  = 0;

  // Q30 product, magnitude rounded half away from zero
  function automatic longint q30_mul(input longint a, input longint b);
    logic neg;
    longint unsigned ua, ub, r;
    neg = (a < 0) != (b < 0);
    ua  = (a < 0) ? -a : a;
    ub  = (b < 0) ? -b : b;
    r   = (ua * ub + 64'd536870912) >> 30;
    return neg ? -longint'(r) : longint'(r);
  endfunction

  // B-spline edge residual, Horner form per segment
  function automatic longint blep_residual(input longint x);
    longint t;
    if (x < K_ONE) begin
      t = q30_mul(K_QUARTER, x) - K_2_3;
      t = q30_mul(t, x);
      t = q30_mul(t, x);
      t = t + K_4_3;
      t = q30_mul(t, x);
      return t - K_ONE;
    end
    t = K_2_3 - q30_mul(K_1_12, x);
    t = q30_mul(t, x);
    t = t - K_TWO;
    t = q30_mul(t, x);
    t = t + K_8_3;
    t = q30_mul(t, x);
    return t - K_4_3;
  endfunction

  // Exact Q1.30 quotient, clipped just below 2
  function automatic longint edge_ratio(input longint unsigned num,
                                        input longint unsigned den);
    longint unsigned r;
    r = (num << 30) / den;
    if (r > RATIO_CEIL) r = RATIO_CEIL;
    return longint'(r);
  endfunction

  // Sawtooth sample in Q2.22 for one phase/step pair
  function automatic logic signed [pbs_pkg::SAMPLE_W-1:0] shaped_sample(
      input logic [PB-1:0] ph, input logic [PB-1:0] st, input logic aa);
    longint unsigned ph_u, st_u, rest;
    longint acc, q;
    ph_u = ph;
    st_u = st;
    rest = (64'd1 << PB) - ph_u;
    acc  = $signed(ph_u << (33 - PB)) - (longint'(1) << 32);
    if (aa && st_u != 0) begin
      if (rest < 2 * st_u) acc = acc + 4 * blep_residual(edge_ratio(rest, st_u));
      if (ph_u < 2 * st_u) acc = acc - 4 * blep_residual(edge_ratio(ph_u, st_u));
    end
    q = (acc + 512) >>> 10;
    if (q > SAMPLE_HI) q = SAMPLE_HI;
    if (q < SAMPLE_LO) q = SAMPLE_LO;
    return q[pbs_pkg::SAMPLE_W-1:0];
  endfunction

  task automatic report_mismatch(input string what, input longint want, input longint got);
    errs++;
    $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
  endtask

  // Watch all three ports at each edge
  always @(posedge clk) begin
    sample_beat_t want;
    sample_beat_t fresh;
    if (!rst_n) begin
      expected_samples.delete();
      antialias_on = 1'b0;
    end else begin
      // result beat against the oldest prediction
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          report_mismatch("unexpected result beat, queued", 0, 1);
        end else begin
          want = expected_samples.pop_front();
          if (out_sample_out !== want.sample)
            report_mismatch("sample_out", want.sample, out_sample_out);
          if (out_end_of_block_out !== want.eob)
            report_mismatch("end_of_block_out", want.eob, out_end_of_block_out);
        end
      end
      // input beat: predict with the current register value
      if (in_valid && in_ready) begin
        fresh.sample = shaped_sample(in_phase, in_phase_step, antialias_on);
        fresh.eob    = in_end_of_block;
        expected_samples.push_back(fresh);
      end
      // register access phase
      if (cfg_psel && cfg_penable && cfg_pready &&
          (cfg_paddr >> pbs_pkg::CFG_IDX_BIT) == pbs_pkg::REG_ANTIALIAS) begin
        if (cfg_pwrite) begin
          antialias_on = cfg_pwdata[0];
        end else if (cfg_prdata !== pbs_pkg::CFG_DATA_W'(antialias_on)) begin
          report_mismatch("antialias_enable readback", antialias_on, cfg_prdata);
        end
      end
    end
    pending    <= expected_samples.size();
    mismatches <= errs;
  end

endmodule

// ===== verif/polyblep_sawtooth_shaper_test.sv =====
// Testbench top for the polyBLEP sawtooth shaper: clock, reset, APB setup,
// directed and random phase/step beats with idling on both channels.
// Depends on pbs_pkg, polyblep_sawtooth_shaper and polyblep_sawtooth_shaper_check.
module polyblep_sawtooth_shaper_test;

  localparam int PB = pbs_pkg::PHASE_BITS_DEF;
  localparam logic [pbs_pkg::CFG_ADDR_W-1:0] ADDR_ANTIALIAS =
      pbs_pkg::CFG_ADDR_W'(pbs_pkg::REG_ANTIALIAS) << pbs_pkg::CFG_IDX_BIT;
  localparam logic [pbs_pkg::CFG_ADDR_W-1:0] ADDR_UNMAPPED =
      pbs_pkg::CFG_ADDR_W'(!pbs_pkg::REG_ANTIALIAS) << pbs_pkg::CFG_IDX_BIT;
  localparam int SINK_HOLD_CYCLES = 150;
  localparam int DRAIN_TAIL       = 20;

  logic                                clk = 1'b0;
  logic                                rst_n;
  logic                                in_valid;
  logic                                in_ready;
  logic [PB-1:0]                       in_phase;
  logic [PB-1:0]                       in_phase_step;
  logic                                in_end_of_block;
  logic                                out_valid;
  logic                                out_ready;
  logic signed [pbs_pkg::SAMPLE_W-1:0] out_sample_out;
  logic                                out_end_of_block_out;
  logic                                cfg_psel;
  logic                                cfg_penable;
  logic                                cfg_pwrite;
  logic [pbs_pkg::CFG_ADDR_W-1:0]      cfg_paddr;
  logic [pbs_pkg::CFG_DATA_W-1:0]      cfg_pwdata;
  logic [pbs_pkg::CFG_DATA_W-1:0]      cfg_prdata;
  logic                                cfg_pready;
  int                                  mismatches;
  int                                  pending;

  // idling controls shared by the source and sink processes
  bit src_gaps    = 1'b1;
  bit sink_stalls = 1'b1;
  bit hold_sink   = 1'b0;

  always #5 clk = ~clk;

  polyblep_sawtooth_shaper i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_phase             (in_phase),
    .in_phase_step        (in_phase_step),
    .in_end_of_block      (in_end_of_block),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_sample_out       (out_sample_out),
    .out_end_of_block_out (out_end_of_block_out),
    .cfg_psel             (cfg_psel),
    .cfg_penable          (cfg_penable),
    .cfg_pwrite           (cfg_pwrite),
    .cfg_paddr            (cfg_paddr),
    .cfg_pwdata           (cfg_pwdata),
    .cfg_prdata           (cfg_prdata),
    .cfg_pready           (cfg_pready)
  );

  polyblep_sawtooth_shaper_check i_check (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_phase             (in_phase),
    .in_phase_step        (in_phase_step),
    .in_end_of_block      (in_end_of_block),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_sample_out       (out_sample_out),
    .out_end_of_block_out (out_end_of_block_out),
    .cfg_psel             (cfg_psel),
    .cfg_penable          (cfg_penable),
    .cfg_pwrite           (cfg_pwrite),
    .cfg_paddr            (cfg_paddr),
    .cfg_pwdata           (cfg_pwdata),
    .cfg_prdata           (cfg_prdata),
    .cfg_pready           (cfg_pready),
    .mismatches           (mismatches),
    .pending              (pending)
  );

  // Step size: zero, full scale, small, medium or anything
  function automatic logic [PB-1:0] pick_step();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return PB'($urandom_range(1, 255));
      4, 5:    return PB'($urandom_range(256, 65535));
      default: return PB'($urandom);
    endcase
  endfunction

  // Phase biased toward the edge zone at each end of the range for the given step
  function automatic logic [PB-1:0] pick_phase(input logic [PB-1:0] st);
    int unsigned span;
    span = 2 * int'(st);
    if (span > 32'hFFFFFF) span = 32'hFFFFFF;
    case ($urandom_range(0, 3))
      0:       return PB'($urandom_range(0, span));
      1:       return PB'(32'hFFFFFF - $urandom_range(0, span));
      default: return PB'($urandom);
    endcase
  endfunction

  // Offer one input beat and wait until it is taken
  task automatic offer(input logic [PB-1:0] ph, input logic [PB-1:0] st, input logic eob);
    if (src_gaps && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_phase        <= ph;
    in_phase_step   <= st;
    in_end_of_block <= eob;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop offering and wait until every predicted sample has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // APB setup and access phases, then deselect and idle
  task automatic cfg_access(input logic wr, input logic [pbs_pkg::CFG_ADDR_W-1:0] addr,
                            input logic [pbs_pkg::CFG_DATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Mix of free-running oscillator sweeps and edge-focused single beats
  task automatic random_beats(input int count);
    logic [PB-1:0] osc_ph, osc_st, st;
    int            run_left;
    int            n;
    osc_st   = pick_step();
    osc_ph   = pick_phase(osc_st);
    run_left = 0;
    for (n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) < 6) begin
        if (run_left == 0) begin
          osc_st   = pick_step();
          osc_ph   = pick_phase(osc_st);
          run_left = $urandom_range(4, 40);
        end
        run_left--;
        offer(osc_ph, osc_st, run_left == 0 || $urandom_range(0, 15) == 0);
        osc_ph = osc_ph + osc_st;
      end else begin
        st = pick_step();
        offer(pick_phase(st), st, $urandom_range(0, 7) == 0);
      end
    end
  endtask

  // Sink: random ready with stall bursts, plus one long hold on request
  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_sink) begin
        out_ready <= 1'b0;
        repeat (SINK_HOLD_CYCLES) @(posedge clk);
        hold_sink = 1'b0;
      end else if (sink_stalls && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // Watchdog
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Source and configuration sequence
  initial begin
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_phase        <= '0;
    in_phase_step   <= '0;
    in_end_of_block <= 1'b0;
    cfg_psel        <= 1'b0;
    cfg_penable     <= 1'b0;
    cfg_pwrite      <= 1'b0;
    cfg_paddr       <= '0;
    cfg_pwdata      <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset value, then the naive ramp at its extremes
    cfg_access(1'b0, ADDR_ANTIALIAS, '0);
    offer(24'h000000, 24'h000000, 1'b0);
    offer(24'hFFFFFF, 24'hFFFFFF, 1'b1);
    offer(24'h800000, 24'h000100, 1'b0);
    offer(24'h000001, 24'h000001, 1'b1);
    drain();

    // antialias on: edge zones, ratio at 0, 1, just under 2, saturated
    cfg_access(1'b1, ADDR_ANTIALIAS, 32'h0000_0001);
    cfg_access(1'b0, ADDR_ANTIALIAS, '0);
    offer(24'h000000, 24'h000001, 1'b0);
    offer(24'hFFFFFF, 24'h000001, 1'b1);
    offer(24'h000000, 24'hFFFFFF, 1'b0);
    offer(24'hFFFFFF, 24'hFFFFFF, 1'b1);
    offer(24'h800000, 24'h400000, 1'b0);
    offer(24'h7FFFFF, 24'h400000, 1'b1);
    offer(24'h800001, 24'h400000, 1'b0);
    offer(24'h000001, 24'hFFFFFF, 1'b0);
    offer(24'hFFFFFE, 24'h000001, 1'b1);
    offer(24'h000002, 24'h000001, 1'b0);
    offer(24'h000000, 24'h800000, 1'b1);
    // zero step keeps the naive ramp
    offer(24'h123456, 24'h000000, 1'b0);
    drain();

    // write to an unmapped address must not touch the register
    cfg_access(1'b1, ADDR_UNMAPPED, 32'h0000_0000);
    cfg_access(1'b0, ADDR_ANTIALIAS, '0);
    offer(24'h000000, 24'h000001, 1'b0);
    offer(24'hFFFFFF, 24'h000002, 1'b1);
    drain();

    random_beats(120);

    // long sink hold while the source keeps pushing, so the pipe backs up
    src_gaps  = 1'b0;
    hold_sink = 1'b1;
    random_beats(40);
    src_gaps = 1'b1;
    drain();

    // bit 0 clear with every upper bit set
    cfg_access(1'b1, ADDR_ANTIALIAS, 32'hFFFF_FFFE);
    cfg_access(1'b0, ADDR_ANTIALIAS, '0);
    random_beats(80);
    drain();

    cfg_access(1'b1, ADDR_ANTIALIAS, 32'hFFFF_FFFF);
    cfg_access(1'b0, ADDR_ANTIALIAS, '0);
    random_beats(130);
    drain();

    // closing stretch at full rate
    src_gaps    = 1'b0;
    sink_stalls = 1'b0;
    random_beats(80);
    drain();
    repeat (DRAIN_TAIL) @(posedge clk);

    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/pbs_pkg.sv
src/polyblep_sawtooth_shaper.sv
verif/polyblep_sawtooth_shaper_check.sv
verif/polyblep_sawtooth_shaper_test.sv
